FILE: sv/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg
// Shared types and constants for the stack machine instruction step block.
// ----------------------------------------------------------------------------
package smi_pkg;

    localparam int PROG_WORDS_DEF = 1024;
    localparam int DATA_DEPTH_DEF = 64;
    localparam int RET_DEPTH_DEF  = 64;
    localparam int MEM_WORDS_DEF  = 256;
    localparam int MAX_FRAMES_DEF = 16;

    localparam int CELL_W = 33;   // bit 32 set when the tag is not numeric
    localparam int WORD_W = 32;

    typedef enum logic [5:0] {
        OP_PUSH  = 6'd0,  OP_POP   = 6'd1,  OP_DUP   = 6'd2,  OP_ADD   = 6'd3,
        OP_SUB   = 6'd4,  OP_MUL   = 6'd5,  OP_DIV   = 6'd6,  OP_JMP   = 6'd7,
        OP_JIT   = 6'd8,  OP_JIF   = 6'd9,  OP_CALL  = 6'd10, OP_RET   = 6'd11,
        OP_STS   = 6'd12, OP_RCS   = 6'd13, OP_EQ    = 6'd14, OP_GT    = 6'd15,
        OP_GE    = 6'd16, OP_LT    = 6'd17, OP_LE    = 6'd18, OP_NE    = 6'd19,
        OP_STO   = 6'd20, OP_RCL   = 6'd21, OP_END   = 6'd22, OP_PRN   = 6'd23,
        OP_RCE   = 6'd24, OP_STL   = 6'd25, OP_ALC   = 6'd26, OP_FRE   = 6'd27,
        OP_ATR   = 6'd28, OP_MOV   = 6'd29, OP_SCH   = 6'd30, OP_GRB   = 6'd31,
        OP_DRP   = 6'd32, OP_ENTRY = 6'd33, OP_LEAVE = 6'd34, OP_ATK   = 6'd35
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_WB
    } t_state;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_TYPE  = 3'd1;
    localparam logic [2:0] ERR_DIV0  = 3'd2;
    localparam logic [2:0] ERR_OVER  = 3'd3;
    localparam logic [2:0] ERR_UNDER = 3'd4;
    localparam logic [2:0] ERR_FRAME = 3'd5;

    localparam logic [2:0] SYS_ATR = 3'd0;
    localparam logic [2:0] SYS_MOV = 3'd1;
    localparam logic [2:0] SYS_SCH = 3'd2;
    localparam logic [2:0] SYS_GRB = 3'd3;
    localparam logic [2:0] SYS_DRP = 3'd4;
    localparam logic [2:0] SYS_ATK = 3'd5;

    // result beat layout
    typedef struct packed {
        logic [2:0]  error_code;
        logic        halted;
        logic [2:0]  syscall_code;
        logic        syscall_valid;
        logic [31:0] print_value;
        logic        print_valid;
        logic [9:0]  next_ip;
    } t_result;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

endpackage

FILE: sv/smi_div.sv
// ----------------------------------------------------------------------------
// smi_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module smi_div
    import smi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic [32:0] r_rem;
    logic [31:0] r_q;
    logic [31:0] r_d;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic        r_done;

    logic [32:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem[31:0], r_q[31]};
    assign w_ge = (w_sh >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
            r_d   <= i_req.divisor[31] ? (32'd0 - i_req.divisor) : i_req.divisor;
            r_rem <= '0;
            r_neg <= i_req.dividend[31] ^ i_req.divisor[31];
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_d}) : w_sh;
            r_q   <= {r_q[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (32'd0 - r_q) : r_q;

endmodule

FILE: sv/stack_machine_instruction_step.sv
// ----------------------------------------------------------------------------
// stack_machine_instruction_step
// Executes one fetched stack-machine instruction per input beat.
// ----------------------------------------------------------------------------
// Input beat: opcode and operand on the slave channel; tuser carries the
// numeric tag of the operand. Each accepted beat yields exactly one result
// beat on the master channel: next fetch address, PRN value, system request
// code, halt flag and error code.
// One instruction is in flight at a time. An ordinary instruction reaches the
// result register through the execute and write-back states; the next beat
// is taken once the block is back in idle. DIV adds a divide state that
// waits for the bit-serial divider. The stack and frame memories are read
// into registers at the accepting edge.
// After reset a clearing pass writes zero through the return stack and frame
// memory, while no beat is accepted.
// A new instruction is accepted while the previous result still waits; a
// stalled receiver holds the next result in write-back, with no state change.
// PROG_WORDS is taken to be a power of two.
// ----------------------------------------------------------------------------
module stack_machine_instruction_step
    import smi_pkg::*;
#(
    parameter int PROG_WORDS = PROG_WORDS_DEF,
    parameter int DATA_DEPTH = DATA_DEPTH_DEF,
    parameter int RET_DEPTH  = RET_DEPTH_DEF,
    parameter int MEM_WORDS  = MEM_WORDS_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // mode[5:0], arg_value[37:6], zero pad
    input  logic        i_s_axis_tuser,   // arg_is_number
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata    // next_ip, print_valid, print_value,
                                          // syscall_valid, syscall_code,
                                          // halted, error_code, zero pad
);

    localparam int PW  = $clog2(PROG_WORDS);
    localparam int DW  = $clog2(DATA_DEPTH);
    localparam int RW  = $clog2(RET_DEPTH);
    localparam int MW  = $clog2(MEM_WORDS);
    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int CLR_LEN = (RET_DEPTH > MEM_WORDS) ? RET_DEPTH : MEM_WORDS;
    localparam int CW  = $clog2(CLR_LEN);
    localparam logic [DW+1:0] DDEP   = (DW+2)'(DATA_DEPTH);
    localparam logic [RW:0]   RDEP   = (RW+1)'(RET_DEPTH);
    localparam logic [31:0]   RDEP32 = 32'(RET_DEPTH);
    localparam logic [31:0]   MEM32  = 32'(MEM_WORDS);
    localparam logic [FW-1:0] FLAST  = FW'(MAX_FRAMES - 1);
    localparam logic [CW:0]   CLR_END = (CW+1)'(CLR_LEN - 1);
    localparam logic [CW:0]   CRET   = (CW+1)'(RET_DEPTH);
    localparam logic [CW:0]   CMEM   = (CW+1)'(MEM_WORDS);

    // memories
    logic [CELL_W-1:0] r_dmem [DATA_DEPTH];
    logic [CELL_W-1:0] r_rmem [RET_DEPTH];
    logic [CELL_W-1:0] r_fmem [MEM_WORDS];
    logic [31:0]       r_bases [MAX_FRAMES];

    // architectural state
    logic [PW-1:0] r_ip;
    logic [DW:0]   r_top;
    logic [RW:0]   r_rtop;
    logic [FW-1:0] r_fidx;
    logic          r_halt;

    t_state r_state, n_state;
    logic   r_clr_busy;
    logic [CW:0] r_clr_cnt;

    // latched instruction
    t_op         r_op;
    logic [31:0] r_av;
    logic        r_num;
    logic [32:0] r_fsum;

    logic [CELL_W-1:0] r_qt, r_qs, r_qr, r_qf;

    // pending write-back
    logic              r_dwe, n_dwe;
    logic [DW-1:0]     r_dwa, n_dwa;
    logic [CELL_W-1:0] r_dwd, n_dwd;
    logic              r_rwe, n_rwe;
    logic [RW-1:0]     r_rwa, n_rwa;
    logic [CELL_W-1:0] r_rwd, n_rwd;
    logic              r_fwe, n_fwe;
    logic [MW-1:0]     r_fwa, n_fwa;
    logic [CELL_W-1:0] r_fwd, n_fwd;
    logic              r_bwe, n_bwe;
    logic [FW-1:0]     r_bwa, n_bwa;
    logic [31:0]       r_bwd, n_bwd;
    logic [DW:0]       r_top_n, n_top;
    logic [RW:0]       r_rtop_n, n_rtop;
    logic [FW-1:0]     r_fidx_n, n_fidx;
    logic [PW-1:0]     r_ip_n, n_ip;
    logic              r_halt_n, n_halt;
    logic              n_is_div;
    t_result           r_res, n_res;

    t_result r_out;
    logic    r_out_valid;

    logic w_acc, w_commit, w_out_free;
    t_div_req w_div_req;
    logic w_div_done;
    logic [31:0] w_quot;

    // ---------------------------------------------------------------- FSM
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_acc      = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_acc)                   n_state = ST_EXEC;
            ST_EXEC: if (n_is_div)                n_state = ST_DIV;
                     else                         n_state = ST_WB;
            ST_DIV:  if (w_div_done)              n_state = ST_WB;
            ST_WB:   if (w_out_free)              n_state = ST_IDLE;
            default:                              n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready    = (r_state == ST_IDLE) && !r_clr_busy;
        w_commit           = (r_state == ST_WB) && w_out_free;
        w_div_req.start    = (r_state == ST_EXEC) && n_is_div;
        w_div_req.dividend = r_qs[31:0];
        w_div_req.divisor  = r_qt[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_END) r_clr_busy <= 1'b0;
            end
        end
    end

    smi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ------------------------------------------------------- read stage
    t_op         w_in_op;
    logic [31:0] w_in_av;
    logic [32:0] w_fsum;
    logic [DW:0] w_tm1, w_tm2;
    logic [RW:0] w_rtm1;

    assign w_in_op = t_op'(i_s_axis_tdata[5:0]);
    assign w_in_av = i_s_axis_tdata[37:6];
    assign w_fsum  = {w_in_av[31], w_in_av} + {r_bases[r_fidx][31], r_bases[r_fidx]};
    assign w_tm1   = r_top - 1'b1;
    assign w_tm2   = r_top - 2'd2;
    assign w_rtm1  = r_rtop - 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op   <= w_in_op;
            r_av   <= w_in_av;
            r_num  <= i_s_axis_tuser;
            r_fsum <= w_fsum;
            r_qt   <= r_dmem[w_tm1[DW-1:0]];
            r_qs   <= r_dmem[w_tm2[DW-1:0]];
            r_qr   <= r_rmem[(w_in_op == OP_RET) ? w_rtm1[RW-1:0] : w_in_av[RW-1:0]];
            r_qf   <= r_fmem[w_fsum[MW-1:0]];
        end
    end

    // ---------------------------------------------------- execute stage
    logic [1:0]        w_pop, w_push;
    logic              w_chk;
    logic [DW+1:0]     w_after;
    logic [2:0]        w_err;
    logic [CELL_W-1:0] w_acell;
    logic signed [31:0] w_a, w_b;
    logic [31:0]       w_alu;
    logic [PW-1:0]     w_target, w_ret_ip;
    logic [DW:0]       w_etm1, w_etm2;
    logic [PW+9:0]     w_ipx;

    assign w_acell  = {!r_num, r_av};
    assign w_a      = $signed(r_qs[31:0]);
    assign w_b      = $signed(r_qt[31:0]);
    assign w_target = r_av[PW-1:0];
    assign w_ret_ip = r_qr[PW-1:0] + 1'b1;
    assign w_etm1   = r_top - 1'b1;
    assign w_etm2   = r_top - 2'd2;

    always_comb begin
        w_pop = 2'd0;
        w_push = 2'd0;
        w_chk = 1'b1;
        case (r_op)
            OP_PUSH, OP_RCL, OP_RCE, OP_ATR, OP_MOV, OP_SCH, OP_GRB, OP_DRP,
            OP_ATK:                          w_push = 2'd1;
            OP_POP, OP_JIT, OP_JIF, OP_STO, OP_PRN, OP_STL: w_pop = 2'd1;
            OP_DUP: begin
                w_pop = 2'd1;
                w_push = 2'd2;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE,
            OP_NE: begin
                w_pop = 2'd2;
                w_push = 2'd1;
            end
            default: w_chk = 1'b0;
        endcase
        w_after = {1'b0, r_top} - (DW+2)'(w_pop) + (DW+2)'(w_push);
    end

    always_comb begin
        case (r_op)
            OP_ADD:  w_alu = r_qs[31:0] + r_qt[31:0];
            OP_SUB:  w_alu = r_qs[31:0] - r_qt[31:0];
            OP_MUL:  w_alu = r_qs[31:0] * r_qt[31:0];
            OP_EQ:   w_alu = {31'd0, w_a == w_b};
            OP_GT:   w_alu = {31'd0, w_a >  w_b};
            OP_GE:   w_alu = {31'd0, w_a >= w_b};
            OP_LT:   w_alu = {31'd0, w_a <  w_b};
            OP_LE:   w_alu = {31'd0, w_a <= w_b};
            OP_NE:   w_alu = {31'd0, w_a != w_b};
            default: w_alu = '0;
        endcase
    end

    always_comb begin
        w_err = ERR_NONE;
        if (w_chk && ({1'b0, r_top} < (DW+2)'(w_pop))) begin
            w_err = ERR_UNDER;
        end else if (w_chk && (w_after > DDEP)) begin
            w_err = ERR_OVER;
        end else begin
            case (r_op)
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE,
                OP_NE: begin
                    if (r_qt[32] || r_qs[32])                  w_err = ERR_TYPE;
                    else if (r_op == OP_DIV && r_qt[31:0] == '0) w_err = ERR_DIV0;
                end
                OP_JIT, OP_JIF: if (r_qt[32]) w_err = ERR_TYPE;
                OP_CALL: if (r_rtop >= RDEP) w_err = ERR_OVER;
                OP_RET: begin
                    if (r_rtop == '0)  w_err = ERR_UNDER;
                    else if (r_qr[32]) w_err = ERR_TYPE;
                end
                OP_STO, OP_RCL: if (r_fsum[32] || r_fsum[31:0] >= MEM32) w_err = ERR_FRAME;
                OP_RCE, OP_STL: if (r_av[31] || r_av >= RDEP32) w_err = ERR_FRAME;
                OP_MOV, OP_SCH, OP_GRB, OP_DRP, OP_ATK: if (!r_num) w_err = ERR_TYPE;
                default: w_err = ERR_NONE;
            endcase
        end
    end

    always_comb begin
        n_dwe = 1'b0;  n_dwa = r_top[DW-1:0];  n_dwd = w_acell;
        n_rwe = 1'b0;  n_rwa = r_rtop[RW-1:0]; n_rwd = {{(CELL_W-PW){1'b0}}, r_ip};
        n_fwe = 1'b0;  n_fwa = r_fsum[MW-1:0]; n_fwd = r_qt;
        n_bwe = 1'b0;  n_bwa = r_fidx + 1'b1;  n_bwd = r_av + 32'(r_fidx);
        n_top = r_top; n_rtop = r_rtop; n_fidx = r_fidx;
        n_ip = r_ip + 1'b1;
        n_halt = r_halt;
        n_is_div = 1'b0;
        n_res = '0;
        if (r_halt) begin
            n_ip = r_ip;
        end else if (w_err != ERR_NONE) begin
            n_ip = r_ip;
            n_halt = 1'b1;
            n_res.error_code = w_err;
        end else begin
            case (r_op)
                OP_PUSH: begin
                    n_dwe = 1'b1;
                    n_top = r_top + 1'b1;
                end
                OP_ATR, OP_MOV, OP_SCH, OP_GRB, OP_DRP, OP_ATK: begin
                    n_dwe = 1'b1;
                    n_top = r_top + 1'b1;
                    n_res.syscall_valid = 1'b1;
                    case (r_op)
                        OP_ATR:  n_res.syscall_code = SYS_ATR;
                        OP_MOV:  n_res.syscall_code = SYS_MOV;
                        OP_SCH:  n_res.syscall_code = SYS_SCH;
                        OP_GRB:  n_res.syscall_code = SYS_GRB;
                        OP_DRP:  n_res.syscall_code = SYS_DRP;
                        default: n_res.syscall_code = SYS_ATK;
                    endcase
                end
                OP_POP: n_top = w_etm1;
                OP_DUP: begin
                    n_dwe = 1'b1;
                    n_dwd = r_qt;
                    n_top = r_top + 1'b1;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE,
                OP_NE: begin
                    n_dwe = 1'b1;
                    n_dwa = w_etm2[DW-1:0];
                    n_dwd = {1'b0, w_alu};
                    n_top = w_etm1;
                    n_is_div = (r_op == OP_DIV);
                end
                OP_JMP: n_ip = w_target;
                OP_JIT, OP_JIF: begin
                    n_top = w_etm1;
                    if ((r_op == OP_JIT) == (r_qt[31:0] != '0)) n_ip = w_target;
                end
                OP_CALL: begin
                    n_rwe = 1'b1;
                    n_rtop = r_rtop + 1'b1;
                    n_ip = w_target;
                end
                OP_RET: begin
                    n_rtop = r_rtop - 1'b1;
                    n_ip = w_ret_ip;
                end
                OP_STO: begin
                    n_fwe = 1'b1;
                    n_top = w_etm1;
                end
                OP_RCL: begin
                    n_dwe = 1'b1;
                    n_dwd = r_qf;
                    n_top = r_top + 1'b1;
                end
                OP_RCE: begin
                    n_dwe = 1'b1;
                    n_dwd = r_qr;
                    n_top = r_top + 1'b1;
                end
                OP_STL: begin
                    n_rwe = 1'b1;
                    n_rwa = r_av[RW-1:0];
                    n_rwd = r_qt;
                    n_top = w_etm1;
                end
                OP_END: begin
                    n_ip = r_ip;
                    n_halt = 1'b1;
                end
                OP_PRN: begin
                    n_top = w_etm1;
                    n_res.print_valid = 1'b1;
                    n_res.print_value = r_qt[31:0];
                end
                OP_ENTRY: begin
                    if (r_fidx < FLAST) begin
                        n_bwe = 1'b1;
                        n_fidx = r_fidx + 1'b1;
                    end
                end
                OP_LEAVE: if (r_fidx != '0) n_fidx = r_fidx - 1'b1;
                default: n_ip = r_ip + 1'b1;
            endcase
        end
        w_ipx = {10'd0, n_ip};
        n_res.next_ip = w_ipx[9:0];
        n_res.halted  = n_halt;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_dwe <= n_dwe;  r_dwa <= n_dwa;  r_dwd <= n_dwd;
            r_rwe <= n_rwe;  r_rwa <= n_rwa;  r_rwd <= n_rwd;
            r_fwe <= n_fwe;  r_fwa <= n_fwa;  r_fwd <= n_fwd;
            r_bwe <= n_bwe;  r_bwa <= n_bwa;  r_bwd <= n_bwd;
            r_top_n <= n_top;  r_rtop_n <= n_rtop;  r_fidx_n <= n_fidx;
            r_ip_n <= n_ip;    r_halt_n <= n_halt;  r_res <= n_res;
        end else if (r_state == ST_DIV && w_div_done) begin
            r_dwd <= {1'b0, w_quot};
        end
    end

    // ------------------------------------------------- write-back stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip        <= '0;
            r_top       <= '0;
            r_rtop      <= '0;
            r_fidx      <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++) r_bases[i] <= '0;
        end else begin
            if (w_commit) begin
                r_ip        <= r_ip_n;
                r_top       <= r_top_n;
                r_rtop      <= r_rtop_n;
                r_fidx      <= r_fidx_n;
                r_halt      <= r_halt_n;
                r_out_valid <= 1'b1;
                if (r_bwe) r_bases[r_bwa] <= r_bwd;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) r_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_commit && r_dwe) r_dmem[r_dwa] <= r_dwd;
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (r_clr_cnt < CRET) r_rmem[r_clr_cnt[RW-1:0]] <= '0;
        end else if (w_commit && r_rwe) begin
            r_rmem[r_rwa] <= r_rwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (r_clr_cnt < CMEM) r_fmem[r_clr_cnt[MW-1:0]] <= '0;
        end else if (w_commit && r_fwe) begin
            r_fmem[r_fwa] <= r_fwd;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out};

endmodule

FILE: sv/smi_checker.sv
// ----------------------------------------------------------------------------
// smi_checker
// Port-level checks on the result channel of the instruction step block.
// ----------------------------------------------------------------------------
module smi_checker
    import smi_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic [55:0] o_m_axis_tdata
);

    // a fault always halts
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[50:48] != ERR_NONE) |-> o_m_axis_tdata[47])
        else $error("error reported without halt");

    a_one_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[10] && o_m_axis_tdata[43]))
        else $error("print and system request in one beat");

    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[10]) |-> (o_m_axis_tdata[42:11] == '0))
        else $error("print value without print");

    a_sys_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[43]) |-> (o_m_axis_tdata[46:44] == SYS_ATR))
        else $error("system code without request");

endmodule

bind stack_machine_instruction_step smi_checker u_smi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
